FILE: rtl/gma_pkg.sv
// Package for the gated moving average filter: sizes, state type.
package gma_pkg;

	localparam int WINDOW_DEPTH = 50;
	localparam int DATA_W       = 32;
	localparam int HELD_W       = 6;
	localparam int CNT_W        = $clog2(WINDOW_DEPTH + 1);
	localparam int PTR_W        = (WINDOW_DEPTH > 1) ? $clog2(WINDOW_DEPTH) : 1;
	localparam int SUM_W        = DATA_W + CNT_W;
	localparam int STEP_W       = $clog2(SUM_W + 1);

	localparam logic [DATA_W-1:0] LIMIT_RESET = 32'h0100_0000;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_UPDATE,
		ST_DIVIDE,
		ST_FINISH
	} state_t;

endpackage

FILE: rtl/gated_moving_average_filter.sv
// Gated moving average filter: outlier gate, sample window RAM, serial divider.
//
// Input channel: interval_sample with in_valid / in_stall. A sample whose
// absolute difference from the current average is below reject_limit is
// written into a 50-entry window RAM and added to the running sum; the
// oldest sample is subtracted once the window is full.
// Output channel: average_interval, sample_accepted, samples_held with
// out_valid / out_stall, one result per input item, held in an output register.
// Sequence: an accepted sample passes through update (the oldest entry is
// read at the accepting edge), the restoring divide of the 38-bit sum by
// the count and the output load in the finish state. A rejected sample goes
// straight to finish. The next item can be taken in the cycle after the load,
// so the block takes no new sample while one is in progress.
// Stall: a full output register with out_stall high holds the finished
// result in the finish state and keeps in_stall high.
// Reset: arst_n clears count, pointer, sum, average and reject_limit
// returns to 1.0 (Q8.24). The window RAM is not cleared; an entry read
// is used only once written.
// Configuration: cfg_wr_en / cfg_wr_data write reject_limit; write it only
// while the block is idle.
module gated_moving_average_filter
	import gma_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              cfg_wr_en,
	input  logic [DATA_W-1:0] cfg_wr_data,
	input  logic              in_valid,
	output logic              in_stall,
	input  logic [DATA_W-1:0] interval_sample,
	output logic              out_valid,
	input  logic              out_stall,
	output logic [DATA_W-1:0] average_interval,
	output logic              sample_accepted,
	output logic [HELD_W-1:0] samples_held
);

	state_t state_q, state_d;

	logic [DATA_W-1:0] limit_q;
	logic [DATA_W-1:0] avg_q;
	logic [SUM_W-1:0]  sum_q;
	logic [CNT_W-1:0]  count_q;
	logic [PTR_W-1:0]  wptr_q;
	logic [DATA_W-1:0] sample_q;
	logic              accept_q;
	logic [DATA_W-1:0] rd_data_q;
	logic [SUM_W-1:0]  dividend_q;
	logic [CNT_W-1:0]  rem_q;
	logic [STEP_W-1:0] step_q;
	logic              out_valid_q;
	logic [DATA_W-1:0] out_avg_q;
	logic              out_acc_q;
	logic [CNT_W-1:0]  out_count_q;

	logic [DATA_W-1:0] sample_window [WINDOW_DEPTH];

	logic              in_take;
	logic              out_take;
	logic              out_load;
	logic [DATA_W-1:0] diff;
	logic              gate_pass;
	logic [CNT_W:0]    trial;
	logic              trial_ge;
	logic              div_last;

	// Gate: compare distance from the current average with the limit
	always_comb begin
		diff      = (interval_sample >= avg_q) ? (interval_sample - avg_q)
		                                       : (avg_q - interval_sample);
		gate_pass = diff < limit_q;
	end

	// One restoring divide step
	always_comb begin
		trial    = {rem_q, dividend_q[SUM_W-1]};
		trial_ge = trial >= {1'b0, count_q};
		div_last = step_q == STEP_W'(1);
	end

	assign in_take  = in_valid && !in_stall;
	assign out_take = out_valid_q && !out_stall;

	// Next state and handshake outputs
	always_comb begin
		state_d  = state_q;
		in_stall = 1'b1;
		out_load = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				in_stall = 1'b0;
				if (in_valid) begin
					state_d = gate_pass ? ST_UPDATE : ST_FINISH;
				end
			end
			ST_UPDATE: begin
				state_d = ST_DIVIDE;
			end
			ST_DIVIDE: begin
				if (div_last) begin
					state_d = ST_FINISH;
				end
			end
			ST_FINISH: begin
				if (!out_valid_q || !out_stall) begin
					out_load = 1'b1;
					state_d  = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// State register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Filter state and configuration
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			limit_q     <= LIMIT_RESET;
			avg_q       <= '0;
			sum_q       <= '0;
			count_q     <= '0;
			wptr_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_wr_en) begin
				limit_q <= cfg_wr_data;
			end
			// Drop the oldest sample once full, add the new one
			if (state_q == ST_UPDATE) begin
				if (count_q == CNT_W'(WINDOW_DEPTH)) begin
					sum_q <= sum_q - SUM_W'(rd_data_q) + SUM_W'(sample_q);
				end else begin
					sum_q   <= sum_q + SUM_W'(sample_q);
					count_q <= count_q + CNT_W'(1);
				end
				wptr_q <= (wptr_q == PTR_W'(WINDOW_DEPTH - 1)) ? '0 : wptr_q + PTR_W'(1);
			end
			// Take the quotient as the new average
			if (state_q == ST_DIVIDE && div_last) begin
				avg_q <= DATA_W'({dividend_q[SUM_W-2:0], trial_ge});
			end
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_take) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Item capture, divider and output payload
	always_ff @(posedge clk) begin
		if (in_take) begin
			sample_q <= interval_sample;
			accept_q <= gate_pass;
		end
		if (state_q == ST_UPDATE) begin
			dividend_q <= (count_q == CNT_W'(WINDOW_DEPTH))
			              ? sum_q - SUM_W'(rd_data_q) + SUM_W'(sample_q)
			              : sum_q + SUM_W'(sample_q);
			rem_q      <= '0;
			step_q     <= STEP_W'(SUM_W);
		end else if (state_q == ST_DIVIDE) begin
			dividend_q <= {dividend_q[SUM_W-2:0], trial_ge};
			rem_q      <= trial_ge ? CNT_W'(trial - {1'b0, count_q}) : CNT_W'(trial);
			step_q     <= step_q - STEP_W'(1);
		end
		if (out_load) begin
			out_avg_q   <= avg_q;
			out_acc_q   <= accept_q;
			out_count_q <= count_q;
		end
	end

	// Window RAM: read the slot at accept, write it during update
	always_ff @(posedge clk) begin
		if (in_take) begin
			rd_data_q <= sample_window[wptr_q];
		end
		if (state_q == ST_UPDATE) begin
			sample_window[wptr_q] <= sample_q;
		end
	end

	assign out_valid        = out_valid_q;
	assign average_interval = out_avg_q;
	assign sample_accepted  = out_acc_q;
	assign samples_held     = HELD_W'(out_count_q);

	// A result is loaded only from the finish state
	a_load_from_finish: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(state_q) == ST_FINISH)
		else $error("output loaded outside finish state");

	// The count never passes the window depth
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_W'(WINDOW_DEPTH))
		else $error("sample count above window depth");

	// The divider never runs with an empty window
	a_div_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_DIVIDE |-> count_q != '0)
		else $error("divide by zero count");

	// A taken item leaves idle at once
	a_take_leaves_idle: assert property (@(posedge clk) disable iff (!arst_n)
		in_take |=> state_q != ST_IDLE)
		else $error("idle after taking an item");

endmodule
